/* src/rsum_pkg.sv */
// Shared widths and state codes for the range-sum block.
package rsum_pkg;

  localparam int unsigned IDX_W = 10;  // index field width
  localparam int unsigned VAL_W = 32;  // element and sum width
  localparam int unsigned CNT_W = 11;  // element_count register width

  localparam logic [CNT_W-1:0] CNT_RESET = 11'd1024;

  localparam logic CMD_QUERY  = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_UPD   = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_FIN   = 6'b100000
  } rsum_state_e;

endpackage

/* src/range_sum_point_update_blocks.sv */
// Range-sum store with point updates over fixed-size blocks (top level).
//
//  channel | direction | handshake                  | words
//  in      | input     | in_valid_i / in_stall_o    | command, first_index, last_index, new_value
//  out     | output    | out_valid_o / out_stall_i  | range_sum, range_error
//  cfg     | input     | cfg_valid_i / cfg_ready_o  | element_count
//
// Update: read old element and block sum, then write both back.
// Query: walks partial end elements and whole blocks, one memory read per
// cycle on a shared walk pointer. A bad range skips the walk. After reset a
// clearing pass over all MAX_ELEMENTS addresses zeroes both memories; no input
// word is accepted meanwhile.
// One output register: a stalled result only holds the block at its last step.
module range_sum_point_update_blocks #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned BLOCK_SIZE   = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              command_i,
  input  logic [rsum_pkg::IDX_W-1:0]        first_index_i,
  input  logic [rsum_pkg::IDX_W-1:0]        last_index_i,
  input  logic signed [rsum_pkg::VAL_W-1:0] new_value_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [rsum_pkg::VAL_W-1:0] range_sum_o,
  output logic                              range_error_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rsum_pkg::CNT_W-1:0]        cfg_data_i
);
  import rsum_pkg::*;

  localparam int unsigned BLOCK_COUNT = (MAX_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
  localparam int unsigned AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int unsigned BW = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
  localparam int unsigned OW = $clog2(BLOCK_SIZE);
  localparam int unsigned PW = ((AW > OW) ? AW : OW) + 2;
  localparam int unsigned LW = $clog2(MAX_ELEMENTS + 1);
  localparam int unsigned CW = (LW > CNT_W) ? LW : CNT_W;

  rsum_state_e      state_q, state_d;
  logic [CNT_W-1:0] count_q;
  logic [AW-1:0]    clr_cnt_q, clr_cnt_d;
  logic [AW-1:0]    upd_idx_q, upd_idx_d;
  logic [VAL_W-1:0] upd_val_q, upd_val_d;
  logic [PW-1:0]    ptr_q, ptr_d;
  logic [PW-1:0]    hi_q, hi_d;
  logic [VAL_W-1:0] acc_q, acc_d;
  logic             err_q, err_d;
  logic             pend_q, pend_d;
  logic             pend_blk_q, pend_blk_d;
  logic             out_valid_q, out_valid_d;
  logic [VAL_W-1:0] out_sum_q, out_sum_d;
  logic             out_err_q, out_err_d;

  logic             elem_we, blk_we;
  logic [AW-1:0]    elem_addr;
  logic [BW-1:0]    blk_addr;
  logic [VAL_W-1:0] elem_wdata, blk_wdata, elem_rdata, blk_rdata;

  logic [CW-1:0]    live_cnt;
  logic             accept, out_free, walk_blk;
  logic [PW-1:0]    ptr_next;

  rsum_store #(
    .MAX_ELEMENTS(MAX_ELEMENTS),
    .BLOCK_COUNT (BLOCK_COUNT),
    .AW          (AW),
    .BW          (BW)
  ) u_store (
    .clk_i       (clk_i),
    .elem_we_i   (elem_we),
    .elem_addr_i (elem_addr),
    .elem_wdata_i(elem_wdata),
    .elem_rdata_o(elem_rdata),
    .blk_we_i    (blk_we),
    .blk_addr_i  (blk_addr),
    .blk_wdata_i (blk_wdata),
    .blk_rdata_o (blk_rdata)
  );

  assign cfg_ready_o   = 1'b1;
  assign in_stall_o    = (state_q != ST_IDLE);
  assign accept        = in_valid_i && !in_stall_o;
  assign out_free      = !out_valid_q || !out_stall_i;
  assign out_valid_o   = out_valid_q;
  assign range_sum_o   = out_sum_q;
  assign range_error_o = out_err_q;

  // counts above capacity act as capacity
  assign live_cnt = (CW'(count_q) > CW'(MAX_ELEMENTS)) ? CW'(MAX_ELEMENTS) : CW'(count_q);

  // whole block read when aligned and the block ends inside the range
  assign walk_blk = (ptr_q[OW-1:0] == '0) && ((ptr_q + PW'(BLOCK_SIZE - 1)) <= hi_q);
  assign ptr_next = walk_blk ? (ptr_q + PW'(BLOCK_SIZE)) : (ptr_q + PW'(1));

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    upd_idx_d   = upd_idx_q;
    upd_val_d   = upd_val_q;
    ptr_d       = ptr_q;
    hi_d        = hi_q;
    acc_d       = acc_q;
    err_d       = err_q;
    pend_d      = 1'b0;
    pend_blk_d  = pend_blk_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_sum_d   = out_sum_q;
    out_err_d   = out_err_q;

    elem_we    = 1'b0;
    blk_we     = 1'b0;
    elem_addr  = upd_idx_q;
    blk_addr   = BW'(upd_idx_q >> OW);
    elem_wdata = upd_val_q;
    blk_wdata  = blk_rdata + upd_val_q - elem_rdata;

    if (pend_q) begin
      acc_d = acc_q + (pend_blk_q ? blk_rdata : elem_rdata);
    end

    case (state_q)
      ST_CLEAR: begin
        elem_we    = 1'b1;
        blk_we     = 1'b1;
        elem_addr  = clr_cnt_q;
        blk_addr   = BW'(clr_cnt_q >> OW);
        elem_wdata = '0;
        blk_wdata  = '0;
        clr_cnt_d  = clr_cnt_q + AW'(1);
        if (clr_cnt_q == AW'(MAX_ELEMENTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        elem_addr = AW'(first_index_i);
        blk_addr  = BW'(AW'(first_index_i) >> OW);
        if (accept) begin
          upd_idx_d = AW'(first_index_i);
          upd_val_d = new_value_i;
          ptr_d     = PW'(first_index_i);
          hi_d      = PW'(last_index_i);
          acc_d     = '0;
          err_d     = 1'b0;
          if (command_i == CMD_UPDATE) begin
            if (CW'(first_index_i) < live_cnt) begin
              state_d = ST_UPD;
            end
          end else if ((first_index_i > last_index_i) ||
                       (CW'(last_index_i) >= live_cnt)) begin
            err_d   = 1'b1;
            state_d = ST_FIN;
          end else begin
            state_d = ST_WALK;
          end
        end
      end
      ST_UPD: begin
        elem_we = 1'b1;
        blk_we  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_WALK: begin
        elem_addr  = AW'(ptr_q);
        blk_addr   = BW'(ptr_q >> OW);
        pend_d     = 1'b1;
        pend_blk_d = walk_blk;
        ptr_d      = ptr_next;
        if (ptr_next > hi_q) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_sum_d   = acc_q;
          out_err_d   = err_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      count_q     <= CNT_RESET;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    upd_idx_q  <= upd_idx_d;
    upd_val_q  <= upd_val_d;
    ptr_q      <= ptr_d;
    hi_q       <= hi_d;
    acc_q      <= acc_d;
    err_q      <= err_d;
    pend_blk_q <= pend_blk_d;
    out_sum_q  <= out_sum_d;
    out_err_q  <= out_err_d;
  end

endmodule

/* src/rsum_store.sv */
// Element memory and block-sum memory, single port each, registered read.
module rsum_store #(
  parameter int unsigned MAX_ELEMENTS = 1024,
  parameter int unsigned BLOCK_COUNT  = 32,
  parameter int unsigned AW           = 10,
  parameter int unsigned BW           = 5
) (
  input  logic                        clk_i,
  input  logic                        elem_we_i,
  input  logic [AW-1:0]               elem_addr_i,
  input  logic [rsum_pkg::VAL_W-1:0]  elem_wdata_i,
  output logic [rsum_pkg::VAL_W-1:0]  elem_rdata_o,
  input  logic                        blk_we_i,
  input  logic [BW-1:0]               blk_addr_i,
  input  logic [rsum_pkg::VAL_W-1:0]  blk_wdata_i,
  output logic [rsum_pkg::VAL_W-1:0]  blk_rdata_o
);
  import rsum_pkg::*;

  logic [VAL_W-1:0] elem_mem [MAX_ELEMENTS];
  logic [VAL_W-1:0] blk_mem  [BLOCK_COUNT];

  always_ff @(posedge clk_i) begin
    if (elem_we_i) begin
      elem_mem[elem_addr_i] <= elem_wdata_i;
    end
    elem_rdata_o <= elem_mem[elem_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (blk_we_i) begin
      blk_mem[blk_addr_i] <= blk_wdata_i;
    end
    blk_rdata_o <= blk_mem[blk_addr_i];
  end

endmodule
